// ----- rtl/core/b64e_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the base64 line encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int B64E_GROUP_BYTES = 3;
  localparam int B64E_QUEUE_DEPTH = 2;
  localparam int B64E_LINE_W      = 10;

  localparam logic [7:0] B64E_PAD_CHAR     = 8'h3D;
  localparam logic [7:0] B64E_NEWLINE_CHAR = 8'h0A;

  // request codes
  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // one quad to be written out, with the valid byte count and a trailing newline flag
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       newline;
  } b64e_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64e_qstat_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/b64e_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Takes bytes and finish requests, gathers groups and posts quad jobs.
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    req_type,
  input  logic [7:0]              data_byte,
  input  logic                    cfg_we,
  input  logic [B64E_LINE_W-1:0]  cfg_wdata,
  input  logic                    q_full,
  output logic                    job_we,
  output b64e_job_t               job
);

  logic [B64E_LINE_W-1:0] quads_per_line;
  logic [7:0]             held0;
  logic [7:0]             held1;
  logic [1:0]             held_count;
  logic [1:0]             held_count_next;
  logic [B64E_LINE_W-1:0] quads_on_line;
  logic [B64E_LINE_W-1:0] quads_on_line_next;
  logic [B64E_LINE_W-1:0] quads_inc;
  logic                   accept;
  logic                   emit;

  localparam logic [1:0] FULL_GROUP = 2'(B64E_GROUP_BYTES);
  localparam logic [1:0] LAST_HELD  = 2'(B64E_GROUP_BYTES - 1);

  assign accept    = push && !q_full;
  assign quads_inc = quads_on_line + B64E_LINE_W'(1);

  always_comb begin
    emit               = 1'b0;
    held_count_next    = held_count;
    quads_on_line_next = quads_on_line;
    job.b0             = held0;
    job.b1             = held1;
    job.b2             = 8'h00;
    job.nbytes         = held_count;
    job.newline        = 1'b0;
    if (accept) begin
      if (req_type == REQ_DATA) begin
        if (held_count == LAST_HELD) begin
          emit            = 1'b1;
          job.b2          = data_byte;
          job.nbytes      = FULL_GROUP;
          held_count_next = 2'd0;
        end else begin
          held_count_next = held_count + 2'd1;
        end
      end else if (held_count != 2'd0) begin
        emit            = 1'b1;
        held_count_next = 2'd0;
      end
    end
    // line accounting is done here so the back end only replays characters
    if (emit && quads_per_line != '0) begin
      if (quads_inc >= quads_per_line) begin
        job.newline        = 1'b1;
        quads_on_line_next = '0;
      end else begin
        quads_on_line_next = quads_inc;
      end
    end
  end

  assign job_we = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      quads_per_line <= '0;
      held_count     <= 2'd0;
      quads_on_line  <= '0;
      held0          <= 8'h00;
      held1          <= 8'h00;
    end else begin
      if (cfg_we) begin
        quads_per_line <= cfg_wdata;
      end
      held_count    <= held_count_next;
      quads_on_line <= quads_on_line_next;
      if (accept && req_type == REQ_DATA) begin
        if (held_count == 2'd0) begin
          held0 <= data_byte;
        end
        if (held_count == 2'd1) begin
          held1 <= data_byte;
        end
      end
    end
  end

endmodule

// ----- rtl/core/b64e_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = B64E_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  b64e_job_t   wr_job,
  input  logic        rd_en,
  output b64e_job_t   rd_job,
  output b64e_qstat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_job_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_job     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/b64e_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one character a cycle into the output register, while pop keeps it draining.
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  b64e_job_t   job,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  char_code,
  output logic        last_of_run
);

  localparam logic [2:0] IDX_C0 = 3'd0;
  localparam logic [2:0] IDX_C1 = 3'd1;
  localparam logic [2:0] IDX_C2 = 3'd2;
  localparam logic [2:0] IDX_C3 = 3'd3;
  localparam logic [2:0] IDX_NL = 3'd4;

  logic [2:0] idx;
  logic       out_valid;
  logic       load;
  logic [7:0] ch;
  logic       ch_last;
  logic       two_plus;
  logic       three;
  logic [3:0] lo1;
  logic [1:0] lo2;

  assign two_plus = (job.nbytes > 2'd1);
  assign three    = (job.nbytes > 2'd2);
  assign lo1      = two_plus ? job.b1[7:4] : 4'h0;
  assign lo2      = three ? job.b2[7:6] : 2'b00;

  always_comb begin
    ch      = B64E_NEWLINE_CHAR;
    ch_last = 1'b0;
    unique case (idx)
      IDX_C0: ch = sextet_char(job.b0[7:2]);
      IDX_C1: ch = sextet_char({job.b0[1:0], lo1});
      IDX_C2: ch = two_plus ? sextet_char({job.b1[3:0], lo2}) : B64E_PAD_CHAR;
      IDX_C3: begin
        ch      = three ? sextet_char(job.b2[5:0]) : B64E_PAD_CHAR;
        ch_last = !job.newline;
      end
      default: begin
        ch      = B64E_NEWLINE_CHAR;
        ch_last = 1'b1;
      end
    endcase
  end

  // output register refills in the cycle it is taken, if a job is queued
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && ch_last;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      char_code   <= ch;
      last_of_run <= ch_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= IDX_C0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= ch_last ? IDX_C0 : ((idx == IDX_C3) ? IDX_NL : idx + 3'd1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/base64_encoder_line_wrap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Byte-in, character-out base64 encoder with optional newline insertion.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a transaction is taken when push is high
// and full is low. req_type selects a data byte or a finish (pad and flush).
// Output side is a queue read port: while empty is low the oldest character
// sits on char_code/last_of_run and is taken when pop is high.
// last_of_run marks the final character caused by one input transaction.
// cfg_we/cfg_wdata write quads_per_line (0 = no newlines); write it idle.
// Throughput: one input transaction per cycle while full is low, into a job
// queue of QUEUE_DEPTH quads; the output side gives one character per cycle
// while pop is high, so a group of three bytes drains as 4 or 5 characters
// through the single character output port.
// The job for a quad enters the job queue as the byte that completes it is
// taken; its first character then moves into the output register once free.
// Reset clears the held bytes, line count, quads_per_line, output register and job queue.
// When pop is held low the output register and job queue fill, then full
// rises and input transactions wait; nothing is dropped.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = B64E_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   req_type,
  input  logic [7:0]             data_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             char_code,
  output logic                   last_of_run,
  input  logic                   cfg_we,
  input  logic [B64E_LINE_W-1:0] cfg_wdata
);

  b64e_job_t   wr_job;
  b64e_job_t   head_job;
  b64e_qstat_t q_stat;
  logic        job_we;
  logic        q_pop;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req_type  (req_type),
    .data_byte (data_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_stat.full),
    .job_we    (job_we),
    .job       (wr_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_we),
    .wr_job (wr_job),
    .rd_en  (q_pop),
    .rd_job (head_job),
    .stat   (q_stat)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .q_empty     (q_stat.empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .char_code   (char_code),
    .last_of_run (last_of_run)
  );

  assign full = q_stat.full;

`ifndef SYNTHESIS
  // a newline only ever closes a run
  a_newline_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && char_code == B64E_NEWLINE_CHAR) |-> last_of_run)
    else $error("newline not marked last of run");

  // a run never has a gap: the next character follows at once
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_of_run) |=> !empty)
    else $error("gap inside a run");

  // reset leaves both sides drained
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not clear after reset");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the base64 encoder with line wrapping.
// ----------------------------------------------------------------------------
// Bytes and finish requests go in through the push/full port. A scoreboard
// keeps its own copy of the held bytes, the group count and the line counter,
// and from these it predicts each output character. Every popped character is
// compared with the oldest prediction. The quads-per-line register is changed
// between phases while the block is idle. Both sides stall at random, and the
// run includes a long output stall that fills the block up.
// ----------------------------------------------------------------------------
module testbench;
  import b64e_pkg::*;

  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } b64_char_t;

  class char_scoreboard;
    b64_char_t              pending_chars[$];
    logic [B64E_LINE_W-1:0] wrap;
    logic [B64E_LINE_W-1:0] line_quads;
    logic [7:0]             held [2];
    logic [1:0]             held_cnt;
    int                     errors;

    function new();
      wrap       = '0;
      line_quads = '0;
      held[0]    = '0;
      held[1]    = '0;
      held_cnt   = '0;
      errors     = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void set_wrap(logic [B64E_LINE_W-1:0] v);
      wrap = v;
    endfunction

    function logic [7:0] enc(logic [5:0] v);
      return ALPHABET[511 - 8 * v -: 8];
    endfunction

    function void add_quad(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [1:0] nb);
      logic [7:0] chars [5];
      logic [3:0] lo1;
      logic [1:0] lo2;
      int         count;
      lo1      = (nb > 2'd1) ? b1[7:4] : 4'h0;
      lo2      = (nb > 2'd2) ? b2[7:6] : 2'b00;
      chars[0] = enc(b0[7:2]);
      chars[1] = enc({b0[1:0], lo1});
      chars[2] = (nb > 2'd1) ? enc({b1[3:0], lo2}) : B64E_PAD_CHAR;
      chars[3] = (nb > 2'd2) ? enc(b2[5:0]) : B64E_PAD_CHAR;
      chars[4] = B64E_NEWLINE_CHAR;
      count    = 4;
      // counter is left alone entirely while wrapping is off
      if (wrap != '0) begin
        line_quads = line_quads + 1'b1;
        if (line_quads >= wrap) begin
          line_quads = '0;
          count      = 5;
        end
      end
      for (int k = 0; k < count; k++) begin
        pending_chars.push_back(b64_char_t'{chars[k], k == count - 1});
      end
    endfunction

    function void note_input(logic req, logic [7:0] b);
      if (req == REQ_DATA) begin
        if (held_cnt < 2'd2) begin
          held[held_cnt] = b;
          held_cnt       = held_cnt + 1'b1;
        end else begin
          add_quad(held[0], held[1], b, 2'd3);
          held_cnt = '0;
        end
      end else if (held_cnt != '0) begin
        add_quad(held[0], held[1], 8'h00, held_cnt);
        held_cnt = '0;
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      b64_char_t exp_c;
      if (pending_chars.size() == 0) begin
        $error("char_code: expected none, actual %02h", code);
        errors++;
        return;
      end
      exp_c = pending_chars.pop_front();
      if (code !== exp_c.code) begin
        $error("char_code: expected %02h, actual %02h", exp_c.code, code);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last_of_run: expected %0b, actual %0b", exp_c.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   push      = 1'b0;
  logic                   full;
  logic                   req_type  = 1'b0;
  logic [7:0]             data_byte = 8'h00;
  logic                   empty;
  logic                   pop       = 1'b0;
  logic [7:0]             char_code;
  logic                   last_of_run;
  logic                   cfg_we    = 1'b0;
  logic [B64E_LINE_W-1:0] cfg_wdata = '0;

  char_scoreboard sb;
  bit             no_idle      = 1'b0;
  bit             rx_long_hold = 1'b0;

  base64_encoder_line_wrap DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .empty       (empty),
    .pop         (pop),
    .char_code   (char_code),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // offer one transaction, hold it until taken, then maybe leave a gap
  task automatic send(input logic req, input logic [7:0] b);
    push      <= 1'b1;
    req_type  <= req;
    data_byte <= b;
    do @(posedge clk); while (full);
    sb.note_input(req, b);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every predicted character, plus pipeline slack
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_wrap(input logic [B64E_LINE_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_wrap(v);
  endtask

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        stall_left   = 300;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      pop <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
      @(posedge clk);
      if (pop && !empty) sb.check_char(char_code, last_of_run);
    end
  end

  initial begin : stimulus
    logic [B64E_LINE_W-1:0] wrap_settings [6];
    sb = new();
    wrap_settings[0] = 10'd0;
    wrap_settings[1] = 10'd1023;
    wrap_settings[2] = 10'd2;
    wrap_settings[3] = 10'd1;
    wrap_settings[4] = B64E_LINE_W'($urandom_range(3, 20));
    wrap_settings[5] = 10'd4;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_wrap(10'd3);
    send(REQ_DATA, 8'h00);
    send(REQ_DATA, 8'h00);
    send(REQ_DATA, 8'h00);
    send(REQ_DATA, 8'hFF);
    send(REQ_DATA, 8'hFF);
    send(REQ_DATA, 8'hFF);
    // finish with nothing held gives no transaction out
    send(REQ_FINISH, 8'hA5);
    send(REQ_DATA, 8'h80);
    send(REQ_FINISH, 8'h00);
    send(REQ_DATA, 8'h12);
    send(REQ_DATA, 8'h34);
    send(REQ_FINISH, 8'hFF);
    send(REQ_FINISH, 8'h5A);
    send(REQ_DATA, 8'h4D);
    send(REQ_DATA, 8'h61);
    send(REQ_DATA, 8'h6E);
    // line count now sits above the new limit, so the next quad ends the line
    write_wrap(10'd1);
    send(REQ_DATA, 8'hFC);
    send(REQ_DATA, 8'h0F);
    send(REQ_DATA, 8'hC0);
    send(REQ_DATA, 8'h3F);
    send(REQ_FINISH, 8'hC3);

    for (int p = 0; p < 6; p++) begin
      write_wrap(wrap_settings[p]);
      if (p == 5) no_idle = 1'b1;
      // output side stalls long enough for full to rise
      if (p == 2) rx_long_hold = 1'b1;
      for (int i = 0; i < 42; i++) begin
        if (p == 3 && i == 21) drain();
        send(($urandom_range(0, 7) == 0) ? REQ_FINISH : REQ_DATA,
             8'($urandom_range(0, 255)));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
